// File: design/rfp_pkg.sv
// Package for the frame parser: payload structs, character codes, tag codes
// and the header number parser. Depends on nothing.
package rfp_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int NUM_W = 64;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_FRAME = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [2:0] RL_TYPE    = 3'd0;
    localparam logic [2:0] RL_LINE    = 3'd1;
    localparam logic [2:0] RL_CR      = 3'd2;
    localparam logic [2:0] RL_LF      = 3'd3;
    localparam logic [2:0] RL_PAYLOAD = 3'd4;
    localparam logic [2:0] RL_TRAILER = 3'd5;
    localparam logic [2:0] RL_BOOL    = 3'd6;

    localparam logic [3:0] VT_SIMPLE = 4'd0;
    localparam logic [3:0] VT_ERROR  = 4'd1;
    localparam logic [3:0] VT_INT    = 4'd2;
    localparam logic [3:0] VT_BULK   = 4'd3;
    localparam logic [3:0] VT_ARRAY  = 4'd4;
    localparam logic [3:0] VT_MAP    = 4'd5;
    localparam logic [3:0] VT_SET    = 4'd6;
    localparam logic [3:0] VT_BOOL   = 4'd7;
    localparam logic [3:0] VT_BIGNUM = 4'd8;
    localparam logic [3:0] VT_NULL   = 4'd9;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        byte_role;
        logic [3:0]        value_type;
        logic [2:0]        nesting;
        logic              element_done;
        logic signed [63:0] number_value;
        logic              bool_value;
        logic [31:0]       frame_bytes;
    } result_t;

    typedef struct packed {
        logic neg;
        logic sign;
        logic digit;
        logic ended;
        logic bad;
    } num_flags_t;

    typedef struct packed {
        logic [NUM_W-1:0] acc;
        num_flags_t       flags;
    } num_state_t;

    // Commands to the child count stack.
    typedef struct packed {
        logic             clear;
        logic             push;
        logic             finish;
        logic [NUM_W-1:0] count;
    } stack_cmd_t;

    // Feeds one header byte into the number parser: leading whitespace, an
    // optional sign, digits, and anything after the digits is ignored.
    function automatic num_state_t num_feed(num_state_t s, logic [7:0] c);
        num_state_t       r;
        logic [NUM_W-1:0] lim;
        logic [NUM_W+3:0] prod;
        r = s;
        lim = s.flags.neg ? {1'b1, {(NUM_W-1){1'b0}}} : {1'b0, {(NUM_W-1){1'b1}}};
        prod = {s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {{NUM_W{1'b0}}, c[3:0]};
        if (s.flags.ended || s.flags.bad) begin
            r = s;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (prod > {4'b0000, lim}) begin
                r.flags.bad = 1'b1;
            end else begin
                r.acc = prod[NUM_W-1:0];
                r.flags.digit = 1'b1;
            end
        end else if (s.flags.digit) begin
            r.flags.ended = 1'b1;
        end else if (s.flags.sign) begin
            r.flags.bad = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT
                     || c == CH_FF || c == CH_CR) begin
            r = s;
        end else if (c == CH_PLUS) begin
            r.flags.sign = 1'b1;
        end else if (c == CH_MINUS) begin
            r.flags.sign = 1'b1;
            r.flags.neg = 1'b1;
        end else begin
            r.flags.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: design/rfp_if.sv
// Handshake channels of the frame parser: input beats, result beats and the
// configuration write. Depends on rfp_pkg.
interface rfp_item_if;
    import rfp_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rfp_result_if;
    import rfp_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/resp_frame_parser_top.sv
// Top level of the byte-serial frame parser: decode of one stream byte per
// beat and the registered result stage. Depends on rfp_pkg, rfp_if, rfp_stack.
//
// Usage: every beat on the item channel carries one operation. A data beat
// feeds one raw byte of the stream, and an abort beat drops the frame, clears
// a latched error and returns the parser to the idle state. Every item beat
// produces exactly one result beat that tags the byte with its role, the type
// of its element, the nesting level and, on the end of a header line, the
// parsed number.
// The whole decode for a byte happens in the cycle the beat is accepted, and
// the result appears registered on the result channel in the next cycle, at
// a throughput of one beat per cycle while the receiver does not stall. The
// single result register holds each result beat.
// If the receiver stalls, the result register holds its beat and the item
// channel stays ready only when that beat is taken in the same cycle, so no
// beat is lost or repeated.
// The cfg channel writes max_nesting and is always ready; the user writes it
// only while the parser is idle; the block does not enforce it. After reset
// max_nesting is 7, stack and result register are empty and no frame is open.
module resp_frame_parser_top #(
    parameter int STACK_DEPTH = rfp_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rfp_item_if.sink       item,
    rfp_result_if.source   result,
    rfp_cfg_if.sink        cfg
);
    import rfp_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        PH_TYPE    = 8'b0000_0001,
        PH_LINE    = 8'b0000_0010,
        PH_PAYLOAD = 8'b0000_0100,
        PH_TRAILER = 8'b0000_1000,
        PH_BOOLVAL = 8'b0001_0000,
        PH_BOOLCR  = 8'b0010_0000,
        PH_BOOLLF  = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       kind_reg, kind_next;
    logic             pending_cr_reg, pending_cr_next;
    num_state_t       num_reg, num_next;
    logic [62:0]      payload_reg, payload_next;
    logic [1:0]       trailer_reg, trailer_next;
    logic [31:0]      byte_count_reg, byte_count_next;
    logic [2:0]       max_nesting_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          res;
    stack_cmd_t       cmd, cmd_gated;
    logic [LVL_W-1:0] level;
    logic             frame_end;
    logic             accept;

    rfp_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LVL_W       (LVL_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_gated),
        .level     (level),
        .frame_end (frame_end)
    );

    // A new beat enters whenever the result register is empty or drains now.
    assign item.ready = !out_valid_reg || result.ready;
    assign accept = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    always_comb
    begin
        cmd_gated = cmd;
        cmd_gated.clear = cmd.clear && accept;
        cmd_gated.push = cmd.push && accept;
        cmd_gated.finish = cmd.finish && accept;
    end

    always_comb
    begin
        logic [7:0]  c;
        logic        fail;
        logic        done;
        logic [3:0]  kind;
        logic        neg;
        logic        isneg;
        logic        minus1;
        logic [31:0] cnt_sat;
        num_state_t  ns;

        c = item.data.data_byte;
        fail = 1'b0;
        done = 1'b0;
        kind = kind_reg;
        neg = num_reg.flags.neg;
        isneg = 1'b0;
        minus1 = 1'b0;
        ns = num_reg;

        phase_next = phase_reg;
        kind_next = kind_reg;
        pending_cr_next = pending_cr_reg;
        num_next = num_reg;
        payload_next = payload_reg;
        trailer_next = trailer_reg;
        cmd = '0;

        cnt_sat = (byte_count_reg == 32'hFFFF_FFFF) ? byte_count_reg : byte_count_reg + 1'b1;
        byte_count_next = cnt_sat;

        res = '0;
        res.status = ST_BUSY;
        res.frame_bytes = cnt_sat;
        res.nesting = (32'(level) > 32'd7) ? 3'd7 : 3'(level);

        if (item.data.operation == OP_ABORT)
        begin
            res = '0;
            phase_next = PH_TYPE;
            kind_next = '0;
            pending_cr_next = 1'b0;
            num_next = '0;
            payload_next = '0;
            trailer_next = '0;
            byte_count_next = '0;
            cmd.clear = 1'b1;
        end
        else if (phase_reg == PH_ERROR)
        begin
            res = '0;
            res.status = ST_BAD;
            res.frame_bytes = cnt_sat;
        end
        else
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    res.byte_role = RL_TYPE;
                    if (32'(level) > 32'(max_nesting_reg))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        case (c)
                            CH_PLUS:   kind = VT_SIMPLE;
                            CH_MINUS:  kind = VT_ERROR;
                            CH_COLON:  kind = VT_INT;
                            CH_DOLLAR: kind = VT_BULK;
                            CH_STAR:   kind = VT_ARRAY;
                            CH_PCT:    kind = VT_MAP;
                            CH_TILDE:  kind = VT_SET;
                            CH_LPAREN: kind = VT_BIGNUM;
                            CH_HASH:   kind = VT_BOOL;
                            default:   fail = 1'b1;
                        endcase
                        if (!fail)
                        begin
                            res.value_type = kind;
                            kind_next = kind;
                            pending_cr_next = 1'b0;
                            num_next = '0;
                            phase_next = (kind == VT_BOOL) ? PH_BOOLVAL : PH_LINE;
                        end
                    end
                end
                PH_LINE:
                begin
                    res.value_type = kind_reg;
                    if (pending_cr_reg && c == CH_LF)
                    begin
                        res.byte_role = RL_LF;
                        pending_cr_next = 1'b0;
                        if (kind_reg == VT_SIMPLE || kind_reg == VT_ERROR
                            || kind_reg == VT_BIGNUM)
                        begin
                            done = 1'b1;
                        end
                        else if (num_reg.flags.bad || !num_reg.flags.digit)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            isneg = neg && num_reg.acc != '0;
                            minus1 = neg && num_reg.acc == {{(NUM_W-1){1'b0}}, 1'b1};
                            res.number_value = neg ? -num_reg.acc : num_reg.acc;
                            if (kind_reg == VT_INT)
                            begin
                                done = 1'b1;
                            end
                            else if (kind_reg == VT_BULK)
                            begin
                                if (minus1)
                                begin
                                    res.value_type = VT_NULL;
                                    done = 1'b1;
                                end
                                else if (isneg)
                                begin
                                    fail = 1'b1;
                                end
                                else if (num_reg.acc == '0)
                                begin
                                    trailer_next = 2'd2;
                                    phase_next = PH_TRAILER;
                                end
                                else
                                begin
                                    payload_next = num_reg.acc[62:0];
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                            else
                            begin
                                if (kind_reg != VT_MAP && minus1)
                                begin
                                    res.value_type = VT_NULL;
                                    done = 1'b1;
                                end
                                else if (isneg)
                                begin
                                    fail = 1'b1;
                                end
                                else if (num_reg.acc == '0)
                                begin
                                    done = 1'b1;
                                end
                                else if (32'(level) >= 32'(STACK_DEPTH))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    cmd.push = 1'b1;
                                    cmd.count = (kind_reg == VT_MAP)
                                        ? {num_reg.acc[62:0], 1'b0} : num_reg.acc;
                                    phase_next = PH_TYPE;
                                end
                            end
                        end
                    end
                    else
                    begin
                        // A held CR that was not followed by LF is header content.
                        if (pending_cr_reg)
                        begin
                            ns = num_feed(ns, CH_CR);
                        end
                        pending_cr_next = 1'b0;
                        if (c == CH_CR)
                        begin
                            res.byte_role = RL_CR;
                            pending_cr_next = 1'b1;
                        end
                        else
                        begin
                            res.byte_role = RL_LINE;
                            ns = num_feed(ns, c);
                        end
                        num_next = ns;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.byte_role = RL_PAYLOAD;
                    res.value_type = VT_BULK;
                    payload_next = payload_reg - 1'b1;
                    if (payload_next == '0)
                    begin
                        trailer_next = 2'd2;
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    res.byte_role = RL_TRAILER;
                    res.value_type = VT_BULK;
                    trailer_next = trailer_reg - 1'b1;
                    if (trailer_next == '0)
                    begin
                        done = 1'b1;
                    end
                end
                PH_BOOLVAL:
                begin
                    res.byte_role = RL_BOOL;
                    res.value_type = VT_BOOL;
                    num_next.acc = {{(NUM_W-1){1'b0}}, c == CH_T};
                    res.bool_value = (c == CH_T);
                    phase_next = PH_BOOLCR;
                end
                PH_BOOLCR:
                begin
                    res.byte_role = RL_CR;
                    res.value_type = VT_BOOL;
                    res.bool_value = num_reg.acc[0];
                    if (c != CH_CR)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BOOLLF;
                    end
                end
                PH_BOOLLF:
                begin
                    res.byte_role = RL_LF;
                    res.value_type = VT_BOOL;
                    res.bool_value = num_reg.acc[0];
                    if (c != CH_LF)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase

            if (fail)
            begin
                phase_next = PH_ERROR;
                res.status = ST_BAD;
                cmd.push = 1'b0;
            end
            else if (done)
            begin
                res.element_done = 1'b1;
                cmd.finish = 1'b1;
                phase_next = PH_TYPE;
                if (frame_end)
                begin
                    // The last open aggregate closed: the frame is complete.
                    res.status = ST_FRAME;
                    byte_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            kind_reg <= '0;
            pending_cr_reg <= 1'b0;
            num_reg <= '0;
            payload_reg <= '0;
            trailer_reg <= '0;
            byte_count_reg <= '0;
            max_nesting_reg <= 3'd7;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                max_nesting_reg <= cfg.data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg <= kind_next;
                pending_cr_reg <= pending_cr_next;
                num_reg <= num_next;
                payload_reg <= payload_next;
                trailer_reg <= trailer_next;
                byte_count_reg <= byte_count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// File: design/rfp_stack.sv
// Stack of remaining child counts with the current nesting level, and the
// parallel search that unwinds completed aggregates. Depends on rfp_pkg.
module rfp_stack #(
    parameter int STACK_DEPTH = rfp_pkg::STACK_DEPTH_DEF,
    parameter int LVL_W = $clog2(STACK_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfp_pkg::stack_cmd_t  cmd,
    output logic [LVL_W-1:0]     level,
    output logic                 frame_end
);
    import rfp_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [NUM_W-1:0] count_reg [STACK_DEPTH];
    logic [LVL_W-1:0] level_reg;
    logic [IDX_W-1:0] found;
    logic             any;

    // Highest level below the current one whose count does not drop to zero.
    always_comb
    begin
        found = '0;
        any = 1'b0;
        for (int p = 0; p < STACK_DEPTH; p++)
        begin
            if (LVL_W'(p) < level_reg && count_reg[p] != {{(NUM_W-1){1'b0}}, 1'b1})
            begin
                found = IDX_W'(p);
                any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int p = 0; p < STACK_DEPTH; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            level_reg <= '0;
            for (int p = 0; p < STACK_DEPTH; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else if (cmd.push)
        begin
            count_reg[level_reg[IDX_W-1:0]] <= cmd.count;
            level_reg <= level_reg + 1'b1;
        end
        else if (cmd.finish)
        begin
            for (int p = 0; p < STACK_DEPTH; p++)
            begin
                if (any && IDX_W'(p) == found)
                begin
                    count_reg[p] <= count_reg[p] - 1'b1;
                end
                else if (LVL_W'(p) < level_reg && (!any || IDX_W'(p) > found))
                begin
                    count_reg[p] <= '0;
                end
            end
            level_reg <= any ? LVL_W'(found) + 1'b1 : '0;
        end
    end

    assign level = level_reg;
    assign frame_end = !any;

endmodule

// File: tb/rfp_checker.sv
// Checker for the frame parser: watches the item, result and cfg channels,
// predicts every result beat and compares it. Depends on rfp_pkg and rfp_if.
`timescale 1ns / 1ps
module rfp_checker (
    input  logic  clk,
    input  logic  rst_n,
    rfp_item_if   item,
    rfp_result_if result,
    rfp_cfg_if    cfg,
    output int    fails,
    output int    pending
);
    import rfp_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE, PH_LINE, PH_PAYLOAD, PH_TRAILER, PH_BOOLVAL, PH_BOOLCR, PH_BOOLLF,
        PH_ERROR
    } phase_t;

    localparam int DEPTH = STACK_DEPTH_DEF;

    logic [2:0]  max_nest;
    phase_t      phase;
    logic [3:0]  kind;
    logic        cr_seen;
    logic [63:0] acc;
    logic        f_neg, f_sign, f_digit, f_end, f_bad;
    logic [63:0] payload_left;
    logic [1:0]  trailer_left;
    logic [63:0] children [DEPTH];
    int          level;
    logic [31:0] byte_cnt;
    logic        err;

    result_t expected_beats[$];

    assign pending = expected_beats.size();

    function automatic void clear_parser();
        phase = PH_TYPE;
        kind = 0;
        cr_seen = 0;
        acc = 0;
        {f_neg, f_sign, f_digit, f_end, f_bad} = 0;
        payload_left = 0;
        trailer_left = 0;
        for (int i = 0; i < DEPTH; i++) children[i] = 0;
        level = 0;
        byte_cnt = 0;
        err = 0;
    endfunction

    // Header digits follow stoll: whitespace, a sign, digits, and the rest ignored.
    function automatic void header_char(logic [7:0] c);
        logic [63:0] d, lim;
        if (f_end || f_bad) return;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 64'(c - CH_ZERO);
            lim = f_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (acc > (lim - d) / 10) f_bad = 1;
            else begin
                acc = acc * 10 + d;
                f_digit = 1;
            end
        end else if (f_digit) f_end = 1;
        else if (f_sign) f_bad = 1;
        else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
                 || c == CH_CR) begin
        end else if (c == CH_PLUS) f_sign = 1;
        else if (c == CH_MINUS) begin
            f_sign = 1;
            f_neg = 1;
        end else f_bad = 1;
    endfunction

    // Closes the current element and walks up through parents that run out.
    function automatic logic close_element();
        int lvl;
        lvl = level;
        phase = PH_TYPE;
        while (lvl > 0) begin
            if (lvl - 1 < DEPTH) begin
                children[lvl-1] = children[lvl-1] - 1;
                if (children[lvl-1] != 0) begin
                    level = lvl;
                    return 0;
                end
            end
            lvl--;
        end
        level = 0;
        return 1;
    endfunction

    function automatic result_t tag_byte(item_t it);
        result_t     r;
        logic        fail, done, frame_end, neg, is_neg, minus1;
        logic [7:0]  c;
        logic [63:0] cnt;
        r = '0;
        fail = 0;
        done = 0;
        frame_end = 0;
        c = it.data_byte;
        if (it.operation == OP_ABORT) begin
            clear_parser();
            return r;
        end
        if (byte_cnt != 32'hFFFF_FFFF) byte_cnt++;
        r.nesting = (level > 7) ? 3'd7 : level[2:0];
        r.status = ST_BUSY;
        if (err) begin
            r = '0;
            r.status = ST_BAD;
            r.frame_bytes = byte_cnt;
            return r;
        end
        case (phase)
            PH_TYPE: begin
                r.byte_role = RL_TYPE;
                if (level > max_nest) fail = 1;
                else begin
                    case (c)
                        CH_PLUS:   kind = VT_SIMPLE;
                        CH_MINUS:  kind = VT_ERROR;
                        CH_COLON:  kind = VT_INT;
                        CH_DOLLAR: kind = VT_BULK;
                        CH_STAR:   kind = VT_ARRAY;
                        CH_PCT:    kind = VT_MAP;
                        CH_TILDE:  kind = VT_SET;
                        CH_LPAREN: kind = VT_BIGNUM;
                        CH_HASH:   kind = VT_BOOL;
                        default:   fail = 1;
                    endcase
                    if (!fail) begin
                        r.value_type = kind;
                        cr_seen = 0;
                        acc = 0;
                        {f_neg, f_sign, f_digit, f_end, f_bad} = 0;
                        phase = (kind == VT_BOOL) ? PH_BOOLVAL : PH_LINE;
                    end
                end
            end
            PH_LINE: begin
                r.value_type = kind;
                if (cr_seen && c == CH_LF) begin
                    r.byte_role = RL_LF;
                    cr_seen = 0;
                    if (kind == VT_SIMPLE || kind == VT_ERROR || kind == VT_BIGNUM) done = 1;
                    else if (f_bad || !f_digit) fail = 1;
                    else begin
                        neg = f_neg;
                        is_neg = neg && acc != 0;
                        minus1 = neg && acc == 1;
                        cnt = acc;
                        r.number_value = neg ? -cnt : cnt;
                        if (kind == VT_INT) done = 1;
                        else if (kind == VT_BULK) begin
                            if (minus1) begin
                                r.value_type = VT_NULL;
                                done = 1;
                            end else if (is_neg) fail = 1;
                            else if (cnt == 0) begin
                                trailer_left = 2;
                                phase = PH_TRAILER;
                            end else begin
                                payload_left = cnt;
                                phase = PH_PAYLOAD;
                            end
                        end else begin
                            if (kind != VT_MAP && minus1) begin
                                r.value_type = VT_NULL;
                                done = 1;
                            end else if (is_neg) fail = 1;
                            else if (cnt == 0) done = 1;
                            else if (level >= DEPTH) fail = 1;
                            else begin
                                children[level] = (kind == VT_MAP) ? cnt * 2 : cnt;
                                level++;
                                phase = PH_TYPE;
                            end
                        end
                    end
                end else begin
                    // A CR without its LF is ordinary line content after all.
                    if (cr_seen) begin
                        header_char(CH_CR);
                        cr_seen = 0;
                    end
                    if (c == CH_CR) begin
                        r.byte_role = RL_CR;
                        cr_seen = 1;
                    end else begin
                        r.byte_role = RL_LINE;
                        header_char(c);
                    end
                end
            end
            PH_PAYLOAD: begin
                r.byte_role = RL_PAYLOAD;
                r.value_type = VT_BULK;
                payload_left = payload_left - 1;
                if (payload_left == 0) begin
                    trailer_left = 2;
                    phase = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                r.byte_role = RL_TRAILER;
                r.value_type = VT_BULK;
                trailer_left = trailer_left - 1;
                if (trailer_left == 0) done = 1;
            end
            PH_BOOLVAL: begin
                r.byte_role = RL_BOOL;
                r.value_type = VT_BOOL;
                acc = (c == CH_T) ? 64'd1 : 64'd0;
                r.bool_value = acc[0];
                phase = PH_BOOLCR;
            end
            PH_BOOLCR: begin
                r.byte_role = RL_CR;
                r.value_type = VT_BOOL;
                r.bool_value = acc[0];
                if (c != CH_CR) fail = 1;
                else phase = PH_BOOLLF;
            end
            PH_BOOLLF: begin
                r.byte_role = RL_LF;
                r.value_type = VT_BOOL;
                r.bool_value = acc[0];
                if (c != CH_LF) fail = 1;
                else done = 1;
            end
            default: fail = 1;
        endcase
        if (fail) begin
            err = 1;
            phase = PH_ERROR;
            r.status = ST_BAD;
            done = 0;
        end else if (done) begin
            frame_end = close_element();
            if (frame_end) r.status = ST_FRAME;
        end
        r.element_done = done;
        r.frame_bytes = byte_cnt;
        if (frame_end) byte_cnt = 0;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: result %s is 0x%0h, expected 0x%0h", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got, want;
        if (!rst_n) begin
            max_nest = 3'd7;
            clear_parser();
            expected_beats.delete();
            fails = 0;
        end else begin
            // A beat taken at the same edge as a register write still sees the old value.
            if (item.valid && item.ready)
                expected_beats = {expected_beats, tag_byte(item.data)};
            if (cfg.valid && cfg.ready) max_nest = cfg.data;
            if (result.valid && result.ready) begin
                got = result.data;
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding", $realtime);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.byte_role !== want.byte_role)
                        report_mismatch("byte_role", got.byte_role, want.byte_role);
                    if (got.value_type !== want.value_type)
                        report_mismatch("value_type", got.value_type, want.value_type);
                    if (got.nesting !== want.nesting)
                        report_mismatch("nesting", got.nesting, want.nesting);
                    if (got.element_done !== want.element_done)
                        report_mismatch("element_done", got.element_done, want.element_done);
                    if (got.number_value !== want.number_value)
                        report_mismatch("number_value", got.number_value, want.number_value);
                    if (got.bool_value !== want.bool_value)
                        report_mismatch("bool_value", got.bool_value, want.bool_value);
                    if (got.frame_bytes !== want.frame_bytes)
                        report_mismatch("frame_bytes", got.frame_bytes, want.frame_bytes);
                end
            end
        end
    end

endmodule

// File: tb/resp_frame_parser_top_tb.sv
// Top of the frame parser testbench: clock, reset, byte stream stimulus,
// configuration phases and the verdict. Depends on rfp_pkg, rfp_if, rfp_checker.
`timescale 1ns / 1ps
module resp_frame_parser_top_tb;
    import rfp_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest honest stall is the long receiver hold.
    localparam int HANG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    rfp_item_if   item ();
    rfp_result_if result ();
    rfp_cfg_if    cfg ();

    int fails;
    int outstanding;

    // Beats waiting to be driven, filled by the frame generators below.
    item_t byte_stream[$];

    // Idling is switched off for the final phase; hold_req asks the receiver
    // for one long stall while the sender keeps offering beats.
    logic quiet;
    logic hold_req;
    int   stall_cnt;

    resp_frame_parser_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    rfp_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .fails   (fails),
        .pending (outstanding)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        item.valid = 0;
        item.data = '0;
        result.ready = 0;
        cfg.valid = 0;
        cfg.data = 0;
        quiet = 0;
        hold_req = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // The watchdog restarts whenever any channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= HANG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: bursts of back-pressure, plus one long hold when asked for.
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result.ready <= 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
                result.ready <= 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 19);
                result.ready <= 0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                result.ready <= 1;
        end
    end

    task automatic put_byte(logic [7:0] b);
        item_t it;
        it.operation = OP_DATA;
        it.data_byte = b;
        byte_stream = {byte_stream, it};
    endtask

    task automatic put_abort();
        item_t it;
        it.operation = OP_ABORT;
        it.data_byte = 8'($urandom_range(0, 255));
        byte_stream = {byte_stream, it};
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Header number text: mostly plain, sometimes with whitespace, a sign or
    // trailing junk, or empty, malformed, or at or past the 64-bit limits.
    function automatic string number_text(int value);
        string s;
        s = "";
        case ($urandom_range(0, 19))
            0: return "9223372036854775807";
            1: return "-9223372036854775808";
            2: return "9223372036854775808";
            3: return "";
            4: return "+-3";
            5: return "x1";
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0) s = {s, " \t"};
        if ($urandom_range(0, 5) == 0) s = {s, "+"};
        s = {s, $sformatf("%0d", value)};
        if ($urandom_range(0, 7) == 0) s = {s, "z7"};
        return s;
    endfunction

    // One element with random content; aggregates recurse with small counts.
    task automatic gen_element(int depth);
        int n, sel;
        sel = $urandom_range(0, 9);
        if (depth >= 9 && sel >= 6) sel = 0;
        case (sel)
            0: begin
                put_byte(CH_PLUS);
                n = $urandom_range(0, 4);
                repeat (n) put_byte(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 6) == 0) put_byte(CH_CR);
                put_text("\r\n");
            end
            1: begin
                put_byte($urandom_range(0, 1) ? CH_MINUS : CH_LPAREN);
                put_text("ERR 12\r\n");
            end
            2: begin
                put_byte(CH_COLON);
                put_text(number_text($urandom_range(0, 200000) - 100000));
                if ($urandom_range(0, 4) == 0) put_byte(CH_CR);
                put_text("\r\n");
            end
            3: begin
                put_byte(CH_DOLLAR);
                if ($urandom_range(0, 5) == 0) put_text("-1\r\n");
                else
                begin
                    n = $urandom_range(0, 4);
                    put_text({$sformatf("%0d", n), "\r\n"});
                    repeat (n + 2) put_byte(8'($urandom_range(0, 255)));
                end
            end
            4, 5: begin
                put_byte(CH_HASH);
                put_byte($urandom_range(0, 1) ? CH_T : 8'($urandom_range(0, 255)));
                put_text("\r\n");
            end
            default: begin
                n = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0: put_byte(CH_STAR);
                    1: put_byte(CH_TILDE);
                    default:
                    begin
                        put_byte(CH_PCT);
                        n = $urandom_range(0, 1);
                        if ($urandom_range(0, 7) == 0) put_text("-1\r\n");
                        else
                        begin
                            put_text({$sformatf("%0d", n), "\r\n"});
                            repeat (2 * n) gen_element(depth + 1);
                        end
                        return;
                    end
                endcase
                if ($urandom_range(0, 7) == 0) put_text("-1\r\n");
                else
                begin
                    put_text({$sformatf("%0d", n), "\r\n"});
                    repeat (n) gen_element(depth + 1);
                end
            end
        endcase
    endtask

    // Mostly well-formed frames; now and then raw noise or a cut-off frame,
    // always followed by an abort so the next frame starts clean.
    task automatic gen_traffic(int count);
        int goal;
        goal = byte_stream.size() + count;
        while (byte_stream.size() < goal)
        begin
            case ($urandom_range(0, 11))
                0: begin
                    repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
                    put_abort();
                end
                1: begin
                    gen_element(0);
                    repeat ($urandom_range(1, 4))
                        if (byte_stream.size() > 0) void'(byte_stream.pop_back());
                    put_abort();
                end
                2: put_abort();
                default: gen_element(0);
            endcase
        end
    endtask

    // Sender: offers each beat at a falling edge and holds it until taken.
    task automatic send_stream();
        item_t it;
        while (byte_stream.size() > 0)
        begin
            it = byte_stream.pop_front();
            @(negedge clk);
            if (!quiet && $urandom_range(0, 11) == 0)
            begin
                item.valid <= 0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            item.valid <= 1;
            item.data <= it;
            do @(posedge clk); while (!item.ready);
        end
        @(negedge clk);
        item.valid <= 0;
    endtask

    // Waits until every predicted result has been checked.
    task automatic drain();
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_nesting(logic [2:0] value);
        @(negedge clk);
        cfg.valid <= 1;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    initial
    begin
        logic [2:0] nest_plan[6];
        nest_plan = '{3'd7, 3'd0, 3'd2, 3'd7, 3'd4, 3'd7};
        @(posedge rst_n);

        // Directed frames: the negative number limit, overflow, a null bulk, an
        // empty aggregate, a map of booleans, a lone CR, an unknown type byte and
        // a beat after a latched error, then an abort.
        put_text(":-9223372036854775808\r\n");
        put_text("$-1\r\n*0\r\n%1\r\n#t\r\n#f\r\n");
        put_text(":1\r2\r\n");
        put_text("?");
        put_byte(8'hFF);
        put_abort();
        put_text(":99999999999999999999\r\n");
        put_abort();
        send_stream();
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_nesting(nest_plan[ph]);
            if (ph == 5) quiet = 1;
            gen_traffic(95);
            // In one phase the receiver stalls for a long stretch while the
            // sender keeps the item channel busy and the parser backs up.
            if (ph == 2) hold_req = 1;
            send_stream();
            // Every phase ends with the sender pausing until all results
            // have arrived, so the next register write happens while idle.
            drain();
        end

        repeat (5) @(posedge clk);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
